// ===== rtl/core/pshc_pkg.sv =====
// ----------------------------------------------------------------------------
// pshc_pkg
// shared types and constants of the pc sample hash counter
// ----------------------------------------------------------------------------
`default_nettype none

package pshc_pkg;

	localparam int TABLE_SIZE   = 4093;
	localparam int STEP_MODULUS = 1024;
	localparam int IDX_W        = 12;
	localparam int STEP_W       = $clog2(STEP_MODULUS + 1);
	localparam int KEY_W        = 30;
	localparam int FOLD         = (1 << IDX_W) - TABLE_SIZE;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
	localparam logic [IDX_W-1:0] OCC_LIMIT = IDX_W'((TABLE_SIZE / 4) * 3);
	localparam logic [31:0]      MAX32     = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		OC_COUNTED  = 3'd0,
		OC_INSERTED = 3'd1,
		OC_DROPPED  = 3'd2,
		OC_IGNORED  = 3'd3,
		OC_CLEARED  = 3'd4,
		OC_READ     = 3'd5
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_PROBE,
		ST_RDATA,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [31:0]      sample_pc;
		logic [IDX_W-1:0] read_index;
	} in_t;

	typedef struct packed {
		logic [2:0]       outcome;
		logic [IDX_W-1:0] slot;
		logic [31:0]      entry_pc;
		logic [31:0]      entry_count;
		logic [IDX_W-1:0] entries_used;
		logic [31:0]      dropped_total;
	} out_t;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] count;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0]  pos;
		logic [STEP_W-1:0] step;
	} hash_t;

endpackage

`default_nettype wire

// ===== rtl/core/pshc_ram.sv =====
// ----------------------------------------------------------------------------
// pshc_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pshc_ram #(
	parameter int DEPTH = 4093,
	parameter int WIDTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pshc_hash.sv =====
// ----------------------------------------------------------------------------
// pshc_hash
// home slot and probe step of a sample key, registered on load
// ----------------------------------------------------------------------------
`default_nettype none

module pshc_hash
	import pshc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic [KEY_W-1:0] key,
	output hash_t                 home
);

	logic [14:0]       fold1;
	logic [IDX_W:0]    fold2;
	logic [IDX_W-1:0]  pos;
	logic [STEP_W-1:0] step;
	hash_t             home_q;

	// 2^12 is congruent to FOLD, fold the key in 12-bit chunks
	always_comb begin
		fold1 = 15'(key[IDX_W-1:0])
			+ 15'(FOLD) * 15'(key[2*IDX_W-1:IDX_W])
			+ 15'(FOLD * FOLD) * 15'(key[KEY_W-1:2*IDX_W]);
		fold2 = (IDX_W+1)'(fold1[IDX_W-1:0]) + (IDX_W+1)'(FOLD) * (IDX_W+1)'(fold1[14:IDX_W]);
		if (fold2 >= (IDX_W+1)'(TABLE_SIZE)) begin
			pos = IDX_W'(fold2 - (IDX_W+1)'(TABLE_SIZE));
		end else begin
			pos = fold2[IDX_W-1:0];
		end
		step = STEP_W'(key % STEP_MODULUS) + STEP_W'(1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			home_q <= '{pos: pos, step: step};
		end
	end

	assign home = home_q;

endmodule

`default_nettype wire

// ===== rtl/core/pc_sample_hash_counter_core.sv =====
// ----------------------------------------------------------------------------
// pc_sample_hash_counter_core
// counts sampled program counters in a double-hashed table of 4093 slots
// ----------------------------------------------------------------------------
// requests enter on in_valid/in_ready, one result per request leaves on
// out_valid/out_ready through an output register. one request is worked on
// at a time; the slot table sits in one ram with registered read data.
// a record request hashes its pc and then probes the table, each probe
// being one ram read followed by a compare and write-back.
// a clear request sweeps the ram one slot a cycle.
// after reset the same clearing pass runs with in_ready low and
// no result; the enable register is taken at any time and resets to 1.
// while the receiver stalls the last result is held in the output register,
// the next request is still taken and worked on, and its result waits in
// the core until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_sample_hash_counter_core
	import pshc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_idx_q;
	logic             clr_emit_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] occ_q;
	logic [31:0]      drop_q;
	logic             enabled_q;
	logic             out_valid_q;
	out_t             out_q;
	out_t             res_q;
	logic [IDX_W-1:0] pos_q;
	logic [STEP_W-1:0] step_q;
	logic [31:0]      pc_q;
	logic [IDX_W-1:0] idx_q;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;
	logic             hash_load;
	hash_t            home;

	logic             accept, out_free, take_record;
	logic             hit, empty, can_insert, probe_last;
	logic [IDX_W:0]   pos_sum;
	logic [IDX_W-1:0] pos_adv;
	logic [31:0]      cnt_sat, drop_sat;

	pshc_hash u_hash (
		.clk  (clk),
		.load (hash_load),
		.key  (in_data.sample_pc[31:2]),
		.home (home)
	);

	pshc_ram #(
		.DEPTH (TABLE_SIZE),
		.WIDTH ($bits(entry_t)),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign take_record = enabled_q && (in_data.sample_pc != 32'd0);
	assign hit         = ram_rdata.pc == pc_q;
	assign empty       = ram_rdata.pc == 32'd0;
	assign can_insert  = occ_q < OCC_LIMIT;
	assign probe_last  = n_q == LAST_IDX;
	assign pos_sum     = {1'b0, pos_q} + (IDX_W+1)'(step_q);
	assign pos_adv     = (pos_sum >= (IDX_W+1)'(TABLE_SIZE))
		? IDX_W'(pos_sum - (IDX_W+1)'(TABLE_SIZE)) : pos_sum[IDX_W-1:0];
	assign cnt_sat     = (ram_rdata.count == MAX32) ? MAX32 : ram_rdata.count + 32'd1;
	assign drop_sat    = (drop_q == MAX32) ? MAX32 : drop_q + 32'd1;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = pos_q;
		hash_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				if (clr_idx_q == LAST_IDX) begin
					state_d = clr_emit_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_data.opcode)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_READ: begin
							ram_re    = in_data.read_index <= LAST_IDX;
							ram_raddr = in_data.read_index;
							state_d   = ST_RDATA;
						end
						OP_RECORD: begin
							hash_load = take_record;
							state_d   = take_record ? ST_ISSUE : ST_EMIT;
						end
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_ISSUE: begin
				ram_re    = 1'b1;
				ram_raddr = home.pos;
				state_d   = ST_PROBE;
			end
			ST_PROBE: begin
				if (hit) begin
					ram_we    = 1'b1;
					ram_wdata = '{pc: pc_q, count: cnt_sat};
					state_d   = ST_EMIT;
				end else if (empty) begin
					ram_we    = can_insert;
					ram_wdata = '{pc: pc_q, count: 32'd1};
					state_d   = ST_EMIT;
				end else if (probe_last) begin
					state_d = ST_EMIT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = pos_adv;
				end
			end
			ST_RDATA: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_emit_q <= 1'b0;
			n_q        <= '0;
			occ_q      <= '0;
			drop_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= (clr_idx_q == LAST_IDX) ? '0 : clr_idx_q + IDX_W'(1);
				end
				ST_IDLE: begin
					n_q <= '0;
					if (accept && in_data.opcode == OP_CLEAR) begin
						clr_idx_q  <= '0;
						clr_emit_q <= 1'b1;
						occ_q      <= '0;
						drop_q     <= '0;
					end
				end
				ST_PROBE: begin
					if (!hit && empty) begin
						if (can_insert) begin
							occ_q <= occ_q + IDX_W'(1);
						end else begin
							drop_q <= drop_sat;
						end
					end else if (!hit) begin
						n_q <= n_q + IDX_W'(1);
						if (probe_last) begin
							drop_q <= drop_sat;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pc_q  <= in_data.sample_pc;
					idx_q <= in_data.read_index;
					case (in_data.opcode)
						OP_CLEAR: res_q <= '{OC_CLEARED, '0, '0, '0, '0, '0};
						OP_READ:  res_q <= '{OC_READ, in_data.read_index, '0, '0, occ_q, drop_q};
						default:  res_q <= '{OC_IGNORED, '0, '0, '0, occ_q, drop_q};
					endcase
				end
			end
			ST_ISSUE: begin
				pos_q  <= home.pos;
				step_q <= home.step;
			end
			ST_PROBE: begin
				if (hit) begin
					res_q <= '{OC_COUNTED, pos_q, pc_q, cnt_sat, occ_q, drop_q};
				end else if (empty) begin
					if (can_insert) begin
						res_q <= '{OC_INSERTED, pos_q, pc_q, 32'd1, occ_q + IDX_W'(1), drop_q};
					end else begin
						res_q <= '{OC_DROPPED, pos_q, '0, '0, occ_q, drop_sat};
					end
				end else begin
					pos_q <= pos_adv;
					if (probe_last) begin
						res_q <= '{OC_DROPPED, pos_adv, '0, '0, occ_q, drop_sat};
					end
				end
			end
			ST_RDATA: begin
				if (idx_q <= LAST_IDX) begin
					res_q.entry_pc    <= ram_rdata.pc;
					res_q.entry_count <= ram_rdata.count;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_occ_limit: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_LIMIT)
		else $error("occupancy above limit");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> pos_q <= LAST_IDX)
		else $error("probe position out of table");

	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.opcode == OP_CLEAR |=> state_q == ST_CLEAR && clr_idx_q == '0)
		else $error("clear request did not start sweep");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_CLEAR || state_q == ST_PROBE)
		else $error("table write outside clear or probe");

endmodule

`default_nettype wire

// ===== verif/pshc_monitor.sv =====
// ----------------------------------------------------------------------------
// pshc_monitor
// Watches the request, result and enable ports of the pc sample hash counter.
// Keeps its own copy of the slot table and counters, works out the result of
// every accepted request and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module pshc_monitor
	import pshc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   fail_count,
	output int   pending,
	output int   n_checked,
	output int   n_inserted,
	output int   n_counted,
	output int   n_dropped,
	output int   n_reads
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0]      tab_pc    [TABLE_SIZE];
	logic [31:0]      tab_count [TABLE_SIZE];
	logic [IDX_W-1:0] used_slots;
	logic [31:0]      drop_tally;
	logic             enabled;
	out_t             owed_reports [$];
	out_t             want;

	function automatic void wipe_table();
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tab_pc[i] = '0;
			tab_count[i] = '0;
		end
		used_slots = '0;
		drop_tally = '0;
	endfunction

	// applies one request to the table copy and returns the report it owes
	function automatic out_t account_request(in_t req);
		out_t r;
		int key;
		int pos;
		int stride;
		int n;
		logic settled;
		logic refuse;
		r = '0;
		if (req.opcode == OP_CLEAR) begin
			wipe_table();
			r.outcome = OC_CLEARED;
		end else if (req.opcode == OP_READ) begin
			r.outcome = OC_READ;
			r.slot = req.read_index;
			if (req.read_index < TABLE_SIZE) begin
				r.entry_pc = tab_pc[req.read_index];
				r.entry_count = tab_count[req.read_index];
			end
		end else if (req.opcode == OP_RECORD && enabled && req.sample_pc != '0) begin
			key = int'(req.sample_pc >> 2);
			pos = key % TABLE_SIZE;
			stride = (key % STEP_MODULUS) + 1;
			settled = 1'b0;
			refuse = 1'b0;
			for (n = 0; n < TABLE_SIZE && !settled; n++) begin
				if (tab_pc[pos] == req.sample_pc) begin
					if (tab_count[pos] != MAX32)
						tab_count[pos]++;
					r.outcome = OC_COUNTED;
					r.entry_pc = req.sample_pc;
					r.entry_count = tab_count[pos];
					settled = 1'b1;
				end else if (tab_pc[pos] == '0) begin
					if (used_slots < OCC_LIMIT) begin
						tab_pc[pos] = req.sample_pc;
						tab_count[pos] = 32'd1;
						used_slots++;
						r.outcome = OC_INSERTED;
						r.entry_pc = req.sample_pc;
						r.entry_count = 32'd1;
					end else begin
						refuse = 1'b1;
					end
					settled = 1'b1;
				end else begin
					pos = (pos + stride) % TABLE_SIZE;
				end
			end
			// occupancy limit reached, or no empty slot on the whole probe path
			if (refuse || !settled) begin
				if (drop_tally != MAX32)
					drop_tally++;
				r.outcome = OC_DROPPED;
			end
			r.slot = IDX_W'(pos);
		end else begin
			r.outcome = OC_IGNORED;
		end
		r.entries_used = used_slots;
		r.dropped_total = drop_tally;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_table();
			enabled = 1'b1;
			owed_reports.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				enabled = cfg_wdata;
			if (out_valid && out_ready) begin
				if (owed_reports.size() == 0) begin
					$error("result with no request pending: outcome %0d slot %0d",
						out_data.outcome, out_data.slot);
					fail_count++;
				end else begin
					want = owed_reports.pop_front();
					n_checked++;
					case (want.outcome)
						OC_INSERTED: n_inserted++;
						OC_COUNTED:  n_counted++;
						OC_DROPPED:  n_dropped++;
						OC_READ:     n_reads++;
						default:     ;
					endcase
					check_field("outcome", 32'(want.outcome), 32'(out_data.outcome));
					check_field("slot", 32'(want.slot), 32'(out_data.slot));
					check_field("entry_pc", want.entry_pc, out_data.entry_pc);
					check_field("entry_count", want.entry_count, out_data.entry_count);
					check_field("entries_used", 32'(want.entries_used),
						32'(out_data.entries_used));
					check_field("dropped_total", want.dropped_total, out_data.dropped_total);
				end
			end
			if (in_valid && in_ready)
				owed_reports.push_back(account_request(in_data));
			pending <= owed_reports.size();
		end
	end

endmodule

// ===== verif/pc_sample_hash_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// pc_sample_hash_counter_core_tb
// Drives the pc sample hash counter with directed requests, mixed random
// traffic, a long fill with distinct pcs and enable changes, with random
// gaps on both channels; a separate monitor predicts and checks.
// ----------------------------------------------------------------------------
module pc_sample_hash_counter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pshc_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         FILL_COUNT = 600;
	localparam int         POOL_SIZE  = 64;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_t         in_data   = '0;
	logic        out_ready = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_ready;
	logic        out_valid;
	out_t        out_data;
	logic        calm      = 1'b0;
	logic [31:0] pc_pool [POOL_SIZE];

	int fail_count;
	int pending;
	int n_checked;
	int n_inserted;
	int n_counted;
	int n_dropped;
	int n_reads;

	pc_sample_hash_counter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	pshc_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.n_checked  (n_checked),
		.n_inserted (n_inserted),
		.n_counted  (n_counted),
		.n_dropped  (n_dropped),
		.n_reads    (n_reads)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 32);
	end

	function automatic in_t op_req(logic [1:0] op);
		in_t r;
		r.opcode = op;
		r.sample_pc = $urandom;
		r.read_index = IDX_W'($urandom);
		return r;
	endfunction

	function automatic in_t sample_req(logic [31:0] pc);
		in_t r;
		r = op_req(OP_RECORD);
		r.sample_pc = pc;
		return r;
	endfunction

	function automatic in_t read_req(logic [IDX_W-1:0] idx);
		in_t r;
		r = op_req(OP_READ);
		r.read_index = idx;
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] home_slot(logic [31:0] pc);
		return IDX_W'((pc >> 2) % TABLE_SIZE);
	endfunction

	task automatic send(in_t req);
		while (!calm && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold off until every result is out and the core is quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_enable(logic value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_mix(int count, int clear_pct);
		int roll;
		logic [31:0] pc;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < clear_pct) begin
				send(op_req(OP_CLEAR));
			end else if (roll < 30) begin
				send(sample_req(pc_pool[$urandom_range(0, POOL_SIZE - 1)]));
			end else if (roll < 55) begin
				pc = $urandom;
				pc_pool[$urandom_range(0, POOL_SIZE - 1)] = pc;
				send(sample_req(pc));
			end else if (roll < 70) begin
				send(read_req(home_slot(pc_pool[$urandom_range(0, POOL_SIZE - 1)])));
			end else if (roll < 82) begin
				send(read_req(IDX_W'($urandom_range(0, (1 << IDX_W) - 1))));
			end else if (roll < 87) begin
				send(sample_req(32'd0));
			end else if (roll < 92) begin
				send(op_req(OP_UNUSED));
			end else begin
				// same key as a known pc but random low bits: collides on the home slot
				pc = pc_pool[$urandom_range(0, POOL_SIZE - 1)];
				send(sample_req({pc[31:2], 2'($urandom)}));
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [31:0] pc;
		for (int i = 0; i < POOL_SIZE; i++)
			pc_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests
		send(read_req('0));
		send(read_req(LAST_IDX));
		send(read_req(IDX_W'(TABLE_SIZE)));
		send(read_req({IDX_W{1'b1}}));
		send(sample_req(32'd0));
		send(sample_req(MAX32));
		send(sample_req(MAX32));
		send(read_req(home_slot(MAX32)));
		send(sample_req(32'd4));
		send(sample_req(32'd5));
		send(sample_req(32'd3));
		send(sample_req(32'(TABLE_SIZE * 4)));
		send(op_req(OP_UNUSED));
		send(read_req(12'd1));
		send(op_req(OP_CLEAR));
		send(read_req(12'd1));
		send(sample_req(32'h8000_0000));
		set_enable(1'b0);
		send(sample_req(32'h1234_5678));
		send(read_req(home_slot(32'h8000_0000)));
		send(op_req(OP_CLEAR));
		send(read_req(home_slot(32'h8000_0000)));
		set_enable(1'b1);
		send(sample_req(32'h1234_5678));
		send(sample_req(32'h1234_5678));

		random_mix(300, 1);
		set_enable(1'b0);
		random_mix(40, 0);
		set_enable(1'b1);

		// long fill with distinct pcs, the first part without gaps
		send(op_req(OP_CLEAR));
		calm = 1'b1;
		for (int i = 0; i < FILL_COUNT; i++) begin
			pc = {16'(i + 1), 16'($urandom)};
			if (i % 50 == 0)
				pc_pool[$urandom_range(0, POOL_SIZE - 1)] = pc;
			if (i == 300)
				calm = 1'b0;
			send(sample_req(pc));
		end
		random_mix(150, 0);
		set_enable(1'b0);
		random_mix(30, 0);
		set_enable(1'b1);
		random_mix(60, 2);

		settle();
		repeat (20) @(posedge clk);
		$display("checked %0d results: %0d inserts, %0d hits on stored pcs, %0d drops",
			n_checked, n_inserted, n_counted, n_dropped);
		$display("%0d slot reads; long distinct-pc fill, enable toggled off and on three times",
			n_reads);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
